/* src/clrs_pkg.sv */
// shared types and constants for the color lookup run segmenter
`default_nettype none

package clrs_pkg;

    localparam int OUT_COL_W  = 11;
    localparam int SIG_W      = 3;
    localparam int MAX_RES    = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        KIND_LINE_START = 2'd0,
        KIND_RUN        = 2'd1,
        KIND_FRAME_END  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [OUT_COL_W-1:0]   start_col;
        logic [OUT_COL_W-1:0]   end_col;
        logic [SIG_W-1:0]       signature;
        logic                   last;
    } res_t;

endpackage

`default_nettype wire

/* src/color_lut_run_segmenter_unit.sv */
// top level: color table lookup, run tracking and result queue
//
// pix channel: one word per cycle while pix_stall is low, either a color table
// write (cmd = 1) or a pixel (cmd = 0) in raster order with line and frame marks.
// seg channel: result words (line start, run segment, frame end); the last
// word caused by one pixel carries last = 1. table writes give no words.
// a pixel's table entry is read into the registered table output when the
// pixel is taken, and its words are then written into an 8-entry result
// queue; a word is offered to the seg port once it is in the queue.
// throughput is one pixel per cycle while pixels average at most one word;
// the seg port drains one word per cycle while seg_stall is low, which bounds longer bursts.
// pix_stall rises whenever the queue may not hold three more words.
// reset clears column, open run, pipeline and queue; table contents are
// undefined until written. when seg_stall is high the head word holds and
// the queue fills until pix_stall takes over.
`default_nettype none

module color_lut_run_segmenter_unit #(
    parameter int LUT_SCALE = 6,
    parameter int COL_BITS  = 11
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           pix_valid,
    output logic                                pix_stall,
    input  wire logic                           cmd,
    input  wire logic [7:0]                     red,
    input  wire logic [7:0]                     green,
    input  wire logic [7:0]                     blue,
    input  wire logic                           first_in_line,
    input  wire logic                           last_in_line,
    input  wire logic                           last_in_frame,
    input  wire logic [11:0]                    table_index,
    input  wire logic [clrs_pkg::SIG_W-1:0]     table_value,
    output logic                                seg_valid,
    input  wire logic                           seg_stall,
    output logic [1:0]                          kind,
    output logic [clrs_pkg::OUT_COL_W-1:0]      start_col,
    output logic [clrs_pkg::OUT_COL_W-1:0]      end_col,
    output logic [clrs_pkg::SIG_W-1:0]          signature,
    output logic                                last
);

    localparam int AW = 2 * LUT_SCALE;
    localparam logic [COL_BITS-1:0] COL_MAX = {COL_BITS{1'b1}};

    logic                              pix_fire;
    logic                              seg_fire;
    logic [8:0]                        u_diff;
    logic [8:0]                        v_diff;
    logic [AW-1:0]                     rd_addr;
    logic [clrs_pkg::SIG_W-1:0]        lut_sig;

    logic                              s1_valid_reg;
    logic                              s1_first_reg;
    logic                              s1_eol_reg;
    logic                              s1_eof_reg;

    logic [COL_BITS-1:0]               col_reg,       col_next;
    logic [clrs_pkg::SIG_W-1:0]        run_sig_reg,   run_sig_next;
    logic [COL_BITS-1:0]               run_start_reg, run_start_next;
    logic [COL_BITS-1:0]               run_end_reg,   run_end_next;
    logic [COL_BITS-1:0]               x_col;

    clrs_pkg::res_t                    slot [clrs_pkg::MAX_RES];
    logic [1:0]                        push_cnt;
    logic [1:0]                        push_eff;

    clrs_pkg::res_t                    fifo_mem [clrs_pkg::FIFO_DEPTH];
    logic [clrs_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [clrs_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [clrs_pkg::FIFO_CW-1:0]      count_reg;
    logic [clrs_pkg::FIFO_CW:0]        room_need;
    clrs_pkg::res_t                    head;

    // input side

    assign pix_fire = pix_valid && !pix_stall;
    assign u_diff   = {1'b0, red}  - {1'b0, green};
    assign v_diff   = {1'b0, blue} - {1'b0, green};
    assign rd_addr  = {u_diff[8 -: LUT_SCALE], v_diff[8 -: LUT_SCALE]};

    clrs_lut_ram #(
        .AW (AW)
    ) u_lut (
        .clk     (clk),
        .wr_en   (pix_fire && (cmd == clrs_pkg::CMD_WRITE)),
        .wr_addr (AW'(table_index)),
        .wr_data (table_value),
        .rd_en   (pix_fire && (cmd == clrs_pkg::CMD_PIXEL)),
        .rd_addr (rd_addr),
        .rd_data (lut_sig)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pix_fire && (cmd == clrs_pkg::CMD_PIXEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_first_reg <= first_in_line;
            s1_eol_reg   <= last_in_line;
            s1_eof_reg   <= last_in_frame;
        end
    end

    // run tracking

    always_comb
    begin
        col_next       = col_reg;
        run_sig_next   = run_sig_reg;
        run_start_next = run_start_reg;
        run_end_next   = run_end_reg;
        push_cnt       = 2'd0;
        x_col          = col_reg;
        for (int k = 0; k < clrs_pkg::MAX_RES; k++)
        begin
            slot[k] = '0;
        end

        if (s1_first_reg)
        begin
            col_next       = '0;
            run_sig_next   = '0;
            run_start_next = '0;
            run_end_next   = '0;
            slot[push_cnt].kind = clrs_pkg::KIND_LINE_START;
            push_cnt = push_cnt + 2'd1;
        end

        x_col = col_next;
        if (run_sig_next == '0)
        begin
            if (lut_sig != '0)
            begin
                run_sig_next   = lut_sig;
                run_start_next = x_col;
                run_end_next   = x_col;
            end
        end
        else if (lut_sig == run_sig_next)
        begin
            run_end_next = x_col;
        end
        else
        begin
            slot[push_cnt].kind      = clrs_pkg::KIND_RUN;
            slot[push_cnt].start_col = clrs_pkg::OUT_COL_W'(run_start_next);
            slot[push_cnt].end_col   = clrs_pkg::OUT_COL_W'(run_end_next);
            slot[push_cnt].signature = run_sig_next;
            push_cnt = push_cnt + 2'd1;
            run_sig_next   = lut_sig;
            run_start_next = (lut_sig != '0) ? x_col : '0;
            run_end_next   = (lut_sig != '0) ? x_col : '0;
        end

        if (col_next != COL_MAX)
        begin
            col_next = col_next + 1'b1;
        end

        if (s1_eol_reg || s1_eof_reg)
        begin
            if (run_sig_next != '0)
            begin
                slot[push_cnt].kind      = clrs_pkg::KIND_RUN;
                slot[push_cnt].start_col = clrs_pkg::OUT_COL_W'(run_start_next);
                slot[push_cnt].end_col   = clrs_pkg::OUT_COL_W'(run_end_next);
                slot[push_cnt].signature = run_sig_next;
                push_cnt = push_cnt + 2'd1;
            end
            run_sig_next   = '0;
            run_start_next = '0;
            run_end_next   = '0;
            col_next       = '0;
            if (s1_eof_reg)
            begin
                slot[push_cnt].kind = clrs_pkg::KIND_FRAME_END;
                push_cnt = push_cnt + 2'd1;
            end
        end

        for (int k = 0; k < clrs_pkg::MAX_RES; k++)
        begin
            slot[k].last = (2'(k) == (push_cnt - 2'd1));
        end
    end

    assign push_eff = s1_valid_reg ? push_cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            run_sig_reg   <= '0;
            run_start_reg <= '0;
            run_end_reg   <= '0;
        end
        else if (s1_valid_reg)
        begin
            col_reg       <= col_next;
            run_sig_reg   <= run_sig_next;
            run_start_reg <= run_start_next;
            run_end_reg   <= run_end_next;
        end
    end

    // result queue

    assign seg_fire  = seg_valid && !seg_stall;
    assign room_need = {1'b0, count_reg}
                     + (s1_valid_reg ? (clrs_pkg::FIFO_CW + 1)'(clrs_pkg::MAX_RES) : '0);
    assign pix_stall = room_need > (clrs_pkg::FIFO_CW + 1)'(clrs_pkg::FIFO_DEPTH
                                                          - clrs_pkg::MAX_RES);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < clrs_pkg::MAX_RES; k++)
        begin
            if (2'(k) < push_eff)
            begin
                fifo_mem[wr_ptr_reg + clrs_pkg::FIFO_AW'(k)] <= slot[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + clrs_pkg::FIFO_AW'(push_eff);
            rd_ptr_reg <= rd_ptr_reg + clrs_pkg::FIFO_AW'(seg_fire);
            count_reg  <= count_reg + clrs_pkg::FIFO_CW'(push_eff)
                        - clrs_pkg::FIFO_CW'(seg_fire);
        end
    end

    assign head      = fifo_mem[rd_ptr_reg];
    assign seg_valid = (count_reg != '0);
    assign kind      = head.kind;
    assign start_col = head.start_col;
    assign end_col   = head.end_col;
    assign signature = head.signature;
    assign last      = head.last;

    // checks

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= clrs_pkg::FIFO_CW'(clrs_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_pixel_reaches_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_fire && (cmd == clrs_pkg::CMD_PIXEL)) |=> s1_valid_reg)
        else $error("accepted pixel lost before lookup");

    a_closed_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (run_sig_reg == '0) |-> (run_start_reg == '0 && run_end_reg == '0))
        else $error("closed run keeps columns");

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        (run_sig_reg != '0) |-> (run_start_reg <= run_end_reg))
        else $error("open run ends before it starts");

    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_valid && head.kind == clrs_pkg::KIND_FRAME_END) |-> head.last)
        else $error("frame end word not marked last");

endmodule

`default_nettype wire

/* src/clrs_lut_ram.sv */
// color table memory, one write port and one registered read port
`default_nettype none

module clrs_lut_ram #(
    parameter int AW = 12
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [clrs_pkg::SIG_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [clrs_pkg::SIG_W-1:0] rd_data
);

    logic [clrs_pkg::SIG_W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
